>>> rtl/ofiq_pkg.sv
// ----------------------------------------------------------------------------
// ofiq_pkg: shared types and constants of the oldest-first issue queue
// entry layout, request codes, unit kinds and latencies
// ----------------------------------------------------------------------------
package ofiq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_UNITS   = 4;
  localparam int TAG_BITS    = 7;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int UIDX_BITS   = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

  typedef logic [TAG_BITS-1:0] tag_t;

  localparam logic [2:0] REQ_ENQ   = 3'd0;
  localparam logic [2:0] REQ_WAKE  = 3'd1;
  localparam logic [2:0] REQ_SEL   = 3'd2;
  localparam logic [2:0] REQ_TICK  = 3'd3;
  localparam logic [2:0] REQ_SDONE = 3'd4;

  localparam logic [1:0] KIND_LOAD  = 2'd2;
  localparam logic [1:0] KIND_STORE = 2'd3;

  localparam logic [1:0] RK_ISSUE  = 2'd0;
  localparam logic [1:0] RK_DONE   = 2'd1;
  localparam logic [1:0] RK_STATUS = 2'd2;

  localparam logic [1:0] CFG_KIND = 2'd0;
  localparam logic [1:0] CFG_CAP  = 2'd1;
  localparam logic [1:0] CFG_UNIT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       s1v;
    logic       s1p;
    tag_t       s1t;
    logic       s2v;
    logic       s2p;
    tag_t       s2t;
    logic       dv;
    tag_t       dt;
    tag_t       odt;
    logic [3:0] sa;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic       wake;
    tag_t       wake_tag;
    logic       sdone;
  } cell_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] entry_kind;
    logic       src1_valid;
    tag_t       src1_tag;
    logic       src1_pending;
    logic       src2_valid;
    tag_t       src2_tag;
    logic       src2_pending;
    logic       dest_valid;
    tag_t       dest_tag;
    tag_t       old_dest_tag;
    logic [3:0] stores_ahead;
  } req_word_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [1:0] unit_index;
    logic       out_dest_valid;
    tag_t       out_dest_tag;
    logic       wake_valid;
    logic       free_valid;
    tag_t       free_tag;
    logic       store_complete;
    logic       dropped;
    logic       queue_full;
    logic       queue_empty;
    logic       last;
  } res_word_t;

  function automatic logic [2:0] kind_latency(input logic [1:0] k);
    logic [2:0] l;
    begin
      l = (k == KIND_LOAD) ? 3'd4 : ((k == KIND_STORE) ? 3'd2 : 3'd1);
      return l;
    end
  endfunction

endpackage

>>> rtl/ofiq_if.sv
// ----------------------------------------------------------------------------
// ofiq_req_if / ofiq_res_if: valid-ready channels of the issue queue
// ----------------------------------------------------------------------------
interface ofiq_req_if;
  import ofiq_pkg::*;
  logic      valid;
  logic      ready;
  req_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ofiq_res_if;
  import ofiq_pkg::*;
  logic      valid;
  logic      ready;
  res_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/oldest_first_issue_queue.sv
// ----------------------------------------------------------------------------
// oldest_first_issue_queue: oldest-first out-of-order issue queue
// chain of entry cells, a unit scoreboard and a stepping sequencer
// ----------------------------------------------------------------------------
// enqueue, wakeup, store done, unknown types give one status word from S_OUT
// select walks the chain one cell per cycle; tick visits one unit per cycle;
// their words are buffered and sent once the walk is over
// words of one request leave back to back unless the receiver stalls; the
// next request is taken the cycle after the last word is taken
// reset (synchronous, active high) empties the queue and idles all units
// ----------------------------------------------------------------------------
module oldest_first_issue_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [4:0]    cfg_data,
  ofiq_req_if.sink      req,
  ofiq_res_if.source    res
);
  import ofiq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE, S_SEL, S_TICK, S_OUT
  } state_t;

  state_t                 state;
  logic [1:0]             queue_kind;
  logic [4:0]             capacity;
  logic [2:0]             unit_count;
  logic [CNT_BITS-1:0]    count;
  logic [CNT_BITS-1:0]    pos;
  logic [UIDX_BITS:0]     upos;

  // words of the current request, sent out once the request is finished
  res_word_t              obuf [MAX_UNITS];
  logic [UIDX_BITS:0]     ocnt;
  logic [UIDX_BITS:0]     optr;
  logic                   ob_we;
  logic [UIDX_BITS-1:0]   ob_idx;
  res_word_t              ob_word;
  res_word_t              issue_w;
  res_word_t              done_w;
  res_word_t              out_w;

  // chain signals
  logic                   c_valid [QUEUE_DEPTH];
  entry_t                 c_entry [QUEUE_DEPTH];
  logic                   c_shift [QUEUE_DEPTH];
  logic                   c_load  [QUEUE_DEPTH];
  cell_cmd_t              cmd;
  entry_t                 enq_entry;

  // unit signals
  logic [MAX_UNITS-1:0]   busy;
  logic                   u_start;
  logic [UIDX_BITS-1:0]   u_idx;
  logic                   tick_done;
  logic [1:0]             done_kind;
  logic                   done_dv;
  tag_t                   done_dt, done_odt;

  logic [CNT_BITS-1:0]    cap_eff;
  logic [UIDX_BITS:0]     nu_eff;
  logic                   full_now;
  entry_t                 cur;
  logic                   cur_ready;
  logic                   idle_found;
  logic [UIDX_BITS-1:0]   idle_idx;

  function automatic res_word_t status_res(input logic drop);
    res_word_t r;
    r = '0;
    r.result_kind = RK_STATUS;
    r.dropped = drop;
    return r;
  endfunction

  assign cap_eff = (capacity > 5'(QUEUE_DEPTH)) ? CNT_BITS'(QUEUE_DEPTH)
                                                : CNT_BITS'(capacity);
  assign nu_eff  = (unit_count > 3'(MAX_UNITS)) ? (UIDX_BITS+1)'(MAX_UNITS)
                                                : (UIDX_BITS+1)'(unit_count);
  assign full_now = count >= cap_eff;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_kind <= 2'd0;
      capacity   <= 5'd16;
      unit_count <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND: queue_kind <= cfg_data[1:0];
        CFG_CAP:  capacity   <= cfg_data;
        CFG_UNIT: unit_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // first idle unit below the unit count
  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int i = MAX_UNITS - 1; i >= 0; i--) begin
      if ((UIDX_BITS+1)'(i) < nu_eff && !busy[i]) begin
        idle_found = 1'b1;
        idle_idx   = UIDX_BITS'(i);
      end
    end
  end

  assign cur = c_entry[pos[CNT_BITS-2:0]];
  assign cur_ready = (pos < count) && cur.kind == queue_kind &&
                     !(cur.s1v && cur.s1p) && !(cur.s2v && cur.s2p) &&
                     !(queue_kind == KIND_LOAD && cur.sa != 4'd0);
  wire issue_now = state == S_SEL && idle_found && cur_ready;
  wire sel_end   = state == S_SEL && (!idle_found || pos >= count);
  wire tick_now  = state == S_TICK && upos < nu_eff;
  wire tick_end  = state == S_TICK && upos >= nu_eff;
  wire emit      = state == S_OUT && (!res.valid || res.ready);

  assign req.ready = state == S_IDLE && !res.valid;
  wire acc = req.valid && req.ready;
  wire sel_or_tick = req.data.req_type == REQ_SEL || req.data.req_type == REQ_TICK;

  // broadcast command to cells
  always_comb begin
    cmd = '0;
    if (acc) begin
      cmd.wake     = req.data.req_type == REQ_WAKE;
      cmd.wake_tag = req.data.dest_tag;
      cmd.sdone    = req.data.req_type == REQ_SDONE;
    end else if (issue_now) begin
      cmd.wake     = cur.dv && cur.kind != KIND_LOAD;
      cmd.wake_tag = cur.dt;
    end
  end

  always_comb begin
    enq_entry.kind = req.data.entry_kind;
    enq_entry.s1v  = req.data.src1_valid;
    enq_entry.s1p  = req.data.src1_pending;
    enq_entry.s1t  = req.data.src1_tag;
    enq_entry.s2v  = req.data.src2_valid;
    enq_entry.s2p  = req.data.src2_pending;
    enq_entry.s2t  = req.data.src2_tag;
    enq_entry.dv   = req.data.dest_valid;
    enq_entry.dt   = req.data.dest_tag;
    enq_entry.odt  = req.data.old_dest_tag;
    enq_entry.sa   = req.data.stores_ahead;
  end

  // issued entry leaves: cells at or above pos shift in from the younger side
  wire enq_ok = acc && req.data.req_type == REQ_ENQ && !full_now &&
                count < CNT_BITS'(QUEUE_DEPTH);
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      c_load[i]  = enq_ok && count == CNT_BITS'(i);
      c_shift[i] = issue_now && pos <= CNT_BITS'(i);
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic   nbv;
    entry_t nbe;
    if (g == QUEUE_DEPTH - 1) begin : g_end
      assign nbv = 1'b0;
      assign nbe = '0;
    end else begin : g_mid
      assign nbv = c_valid[g+1];
      assign nbe = c_entry[g+1];
    end
    ofiq_cell u_cell (
      .clk(clk), .rst(rst), .cmd(cmd), .shift(c_shift[g]), .load(c_load[g]),
      .load_entry(enq_entry), .nb_valid(nbv), .nb_entry(nbe),
      .valid(c_valid[g]), .entry(c_entry[g])
    );
  end

  assign u_start = issue_now;
  assign u_idx   = (state == S_TICK) ? upos[UIDX_BITS-1:0] : idle_idx;

  ofiq_units u_units (
    .clk(clk), .rst(rst), .start(u_start), .start_idx(idle_idx),
    .start_kind(cur.kind), .start_dv(cur.dv), .start_dt(cur.dt),
    .start_odt(cur.odt), .tick(tick_now), .tick_idx(u_idx), .busy(busy),
    .tick_done(tick_done), .done_kind(done_kind), .done_dv(done_dv),
    .done_dt(done_dt), .done_odt(done_odt)
  );

  // issue, completion and outgoing words
  always_comb begin
    issue_w = '0;
    issue_w.result_kind    = RK_ISSUE;
    issue_w.unit_index     = 2'(idle_idx);
    issue_w.out_dest_valid = cur.dv;
    issue_w.out_dest_tag   = cur.dt;
    issue_w.wake_valid     = cur.dv && cur.kind != KIND_LOAD;

    done_w = '0;
    done_w.result_kind    = RK_DONE;
    done_w.unit_index     = 2'(upos[UIDX_BITS-1:0]);
    done_w.out_dest_valid = done_dv;
    done_w.out_dest_tag   = done_dt;
    done_w.wake_valid     = done_dv && done_kind == KIND_LOAD;
    done_w.free_valid     = done_dv;
    done_w.free_tag       = done_dv ? done_odt : '0;
    done_w.store_complete = queue_kind == KIND_STORE;

    // occupancy flags reflect the state after the whole request
    out_w = obuf[optr[UIDX_BITS-1:0]];
    out_w.queue_full  = full_now;
    out_w.queue_empty = count == '0;
    out_w.last        = (optr + (UIDX_BITS+1)'(1)) == ocnt;
  end

  // word buffer write select
  always_comb begin
    ob_we   = 1'b0;
    ob_idx  = ocnt[UIDX_BITS-1:0];
    ob_word = status_res(1'b0);
    if (state == S_IDLE) begin
      ob_we   = acc && !sel_or_tick;
      ob_idx  = '0;
      ob_word = status_res(req.data.req_type == REQ_ENQ && !enq_ok);
    end else if ((sel_end || tick_end) && ocnt == '0) begin
      ob_we = 1'b1;
    end else if (issue_now) begin
      ob_we   = 1'b1;
      ob_word = issue_w;
    end else if (tick_now && tick_done) begin
      ob_we   = 1'b1;
      ob_word = done_w;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_we) begin
      obuf[ob_idx] <= ob_word;
    end
  end

  // sequencer: walk the chain or the units, then send the buffered words
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pos   <= '0;
      upos  <= '0;
      ocnt  <= '0;
      optr  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            pos  <= '0;
            upos <= '0;
            optr <= '0;
            ocnt <= sel_or_tick ? '0 : (UIDX_BITS+1)'(1);
            if (enq_ok) count <= count + CNT_BITS'(1);
            if (req.data.req_type == REQ_SEL) begin
              state <= S_SEL;
            end else if (req.data.req_type == REQ_TICK) begin
              state <= S_TICK;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_SEL: begin
          if (sel_end) begin
            if (ocnt == '0) ocnt <= (UIDX_BITS+1)'(1);
            state <= S_OUT;
          end else if (cur_ready) begin
            ocnt  <= ocnt + (UIDX_BITS+1)'(1);
            count <= count - CNT_BITS'(1);
          end else begin
            pos <= pos + CNT_BITS'(1);
          end
        end
        S_TICK: begin
          if (tick_end) begin
            if (ocnt == '0) ocnt <= (UIDX_BITS+1)'(1);
            state <= S_OUT;
          end else begin
            if (tick_done) ocnt <= ocnt + (UIDX_BITS+1)'(1);
            upos <= upos + (UIDX_BITS+1)'(1);
          end
        end
        S_OUT: begin
          if (emit) begin
            optr <= optr + (UIDX_BITS+1)'(1);
            if (out_w.last) state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
      res.data  <= out_w;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH)) else $error("count overflow");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_issue_unit: assert property (@(posedge clk) disable iff (rst)
    issue_now |=> busy[$past(idle_idx)]) else $error("issued unit not busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.data))
    else $error("result word changed while waiting");
`endif

endmodule

>>> rtl/ofiq_cell.sv
// ----------------------------------------------------------------------------
// ofiq_cell: one queue slot of the age-ordered chain
// holds an entry, applies wakeup and store-done, shifts from its younger
// neighbor when a slot at or below it is removed
// ----------------------------------------------------------------------------
module ofiq_cell (
  input  logic               clk,
  input  logic               rst,
  input  ofiq_pkg::cell_cmd_t cmd,
  input  logic               shift,
  input  logic               load,
  input  ofiq_pkg::entry_t   load_entry,
  input  logic               nb_valid,
  input  ofiq_pkg::entry_t   nb_entry,
  output logic               valid,
  output ofiq_pkg::entry_t   entry
);
  import ofiq_pkg::*;

  entry_t e_upd;
  entry_t nb_upd;

  // apply the broadcast command to an entry
  function automatic entry_t apply(input entry_t e, input cell_cmd_t c);
    entry_t r;
    begin
      r = e;
      if (c.wake && e.s1v && e.s1t == c.wake_tag) r.s1p = 1'b0;
      if (c.wake && e.s2v && e.s2t == c.wake_tag) r.s2p = 1'b0;
      if (c.sdone && e.sa != 4'd0) r.sa = e.sa - 4'd1;
      return r;
    end
  endfunction

  always_comb begin
    e_upd  = apply(entry, cmd);
    nb_upd = apply(nb_entry, cmd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (shift) begin
      valid <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= load_entry;
    end else if (shift) begin
      entry <= nb_upd;
    end else if (valid) begin
      entry <= e_upd;
    end
  end

endmodule

>>> rtl/ofiq_units.sv
// ----------------------------------------------------------------------------
// ofiq_units: functional unit scoreboard
// busy flags, latency countdowns and in-flight instruction info
// ----------------------------------------------------------------------------
module ofiq_units (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ofiq_pkg::UIDX_BITS-1:0]   start_idx,
  input  logic [1:0]                       start_kind,
  input  logic                             start_dv,
  input  ofiq_pkg::tag_t                   start_dt,
  input  ofiq_pkg::tag_t                   start_odt,
  input  logic                             tick,
  input  logic [ofiq_pkg::UIDX_BITS-1:0]   tick_idx,
  output logic [ofiq_pkg::MAX_UNITS-1:0]   busy,
  output logic                             tick_done,
  output logic [1:0]                       done_kind,
  output logic                             done_dv,
  output ofiq_pkg::tag_t                   done_dt,
  output ofiq_pkg::tag_t                   done_odt
);
  import ofiq_pkg::*;

  logic [2:0] cnt  [MAX_UNITS];
  logic [1:0] ukind[MAX_UNITS];
  logic       udv  [MAX_UNITS];
  tag_t       udt  [MAX_UNITS];
  tag_t       uodt [MAX_UNITS];

  assign tick_done = busy[tick_idx] && cnt[tick_idx] <= 3'd1;
  assign done_kind = ukind[tick_idx];
  assign done_dv   = udv[tick_idx];
  assign done_dt   = udt[tick_idx];
  assign done_odt  = uodt[tick_idx];

  // one unit started or ticked per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      for (int i = 0; i < MAX_UNITS; i++) begin
        cnt[i] <= 3'd0;
      end
    end else if (start) begin
      busy[start_idx] <= 1'b1;
      cnt[start_idx]  <= kind_latency(start_kind);
    end else if (tick && busy[tick_idx]) begin
      if (tick_done) begin
        busy[tick_idx] <= 1'b0;
        cnt[tick_idx]  <= 3'd0;
      end else begin
        cnt[tick_idx] <= cnt[tick_idx] - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ukind[start_idx] <= start_kind;
      udv[start_idx]   <= start_dv;
      udt[start_idx]   <= start_dt;
      uodt[start_idx]  <= start_odt;
    end
  end

endmodule

>>> test/oldest_first_issue_queue_tb.sv
// ----------------------------------------------------------------------------
// oldest_first_issue_queue_tb: self-checking bench of the issue queue
// request words go in over a valid-ready channel; every result word is
// compared with a directed word or a behavioral copy of the queue, units and registers
// ----------------------------------------------------------------------------
module oldest_first_issue_queue_tb;
  import ofiq_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  ofiq_req_if req ();
  ofiq_res_if res ();

  oldest_first_issue_queue u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .res(res.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // behavioral copy of the queue
  entry_t     q_entry [QUEUE_DEPTH];
  int         q_count;
  logic       u_busy [MAX_UNITS];
  int         u_left [MAX_UNITS];
  logic [1:0] u_kind [MAX_UNITS];
  logic       u_dv [MAX_UNITS];
  tag_t       u_dt [MAX_UNITS];
  tag_t       u_odt [MAX_UNITS];
  logic [1:0] r_kind;
  logic [4:0] r_cap;
  logic [2:0] r_units;

  res_word_t  expected_words [$];
  res_word_t  step_words [$];
  int         errors;
  int         cycles;
  int         snd_idle;
  int         rcv_idle;

  task automatic wake_entries(input tag_t t);
    for (int i = 0; i < q_count; i++) begin
      if (q_entry[i].s1v && q_entry[i].s1t == t) q_entry[i].s1p = 1'b0;
      if (q_entry[i].s2v && q_entry[i].s2t == t) q_entry[i].s2p = 1'b0;
    end
  endtask

  function automatic res_word_t status_word(input logic drop);
    res_word_t r;
    r = '0;
    r.result_kind = RK_STATUS;
    r.dropped = drop;
    return r;
  endfunction

  task automatic add_step(input res_word_t r);
    step_words = {step_words, r};
  endtask

  // work out the words one request causes and queue them
  task automatic predict_queue(input req_word_t w);
    int         cap;
    int         nu;
    int         nidle;
    int         used;
    int         wr;
    int         idle [MAX_UNITS];
    logic       issued [QUEUE_DEPTH];
    entry_t     e;
    res_word_t  r;
    cap = (r_cap > QUEUE_DEPTH) ? QUEUE_DEPTH : r_cap;
    nu = (r_units > MAX_UNITS) ? MAX_UNITS : r_units;
    step_words.delete();
    case (w.req_type)
      REQ_ENQ: begin
        if (q_count >= cap) begin
          add_step(status_word(1'b1));
        end else begin
          e.kind = w.entry_kind;
          e.s1v = w.src1_valid; e.s1t = w.src1_tag; e.s1p = w.src1_pending;
          e.s2v = w.src2_valid; e.s2t = w.src2_tag; e.s2p = w.src2_pending;
          e.dv = w.dest_valid; e.dt = w.dest_tag; e.odt = w.old_dest_tag;
          e.sa = w.stores_ahead;
          q_entry[q_count] = e;
          q_count++;
          add_step(status_word(1'b0));
        end
      end
      REQ_WAKE: begin
        wake_entries(w.dest_tag);
        add_step(status_word(1'b0));
      end
      REQ_SEL: begin
        nidle = 0;
        used = 0;
        for (int i = 0; i < nu; i++) if (!u_busy[i]) idle[nidle++] = i;
        for (int i = 0; i < QUEUE_DEPTH; i++) issued[i] = 1'b0;
        for (int i = 0; i < q_count; i++) begin
          e = q_entry[i];
          if (used == nidle) break;
          if (e.kind != r_kind) continue;
          if (e.s1v && e.s1p) continue;
          if (e.s2v && e.s2p) continue;
          if (r_kind == KIND_LOAD && e.sa != 0) continue;
          u_busy[idle[used]] = 1'b1;
          u_left[idle[used]] = (e.kind == KIND_LOAD) ? 4 : ((e.kind == KIND_STORE) ? 2 : 1);
          u_kind[idle[used]] = e.kind;
          u_dv[idle[used]] = e.dv;
          u_dt[idle[used]] = e.dt;
          u_odt[idle[used]] = e.odt;
          issued[i] = 1'b1;
          r = '0;
          r.result_kind = RK_ISSUE;
          r.unit_index = 2'(idle[used]);
          r.out_dest_valid = e.dv;
          r.out_dest_tag = e.dt;
          r.wake_valid = e.dv && e.kind != KIND_LOAD;
          add_step(r);
          used++;
          if (r.wake_valid) wake_entries(e.dt);
        end
        wr = 0;
        for (int i = 0; i < q_count; i++) if (!issued[i]) q_entry[wr++] = q_entry[i];
        q_count = wr;
        if (step_words.size() == 0) add_step(status_word(1'b0));
      end
      REQ_TICK: begin
        for (int i = 0; i < nu; i++) begin
          if (!u_busy[i]) continue;
          if (u_left[i] <= 1) begin
            u_left[i] = 0;
            u_busy[i] = 1'b0;
            r = '0;
            r.result_kind = RK_DONE;
            r.unit_index = 2'(i);
            r.out_dest_valid = u_dv[i];
            r.out_dest_tag = u_dt[i];
            r.wake_valid = u_dv[i] && u_kind[i] == KIND_LOAD;
            r.free_valid = u_dv[i];
            r.free_tag = u_dv[i] ? u_odt[i] : '0;
            r.store_complete = (r_kind == KIND_STORE);
            add_step(r);
          end else u_left[i]--;
        end
        if (step_words.size() == 0) add_step(status_word(1'b0));
      end
      REQ_SDONE: begin
        for (int i = 0; i < q_count; i++) if (q_entry[i].sa > 0) q_entry[i].sa--;
        add_step(status_word(1'b0));
      end
      default: add_step(status_word(1'b0));
    endcase
    foreach (step_words[k]) begin
      r = step_words[k];
      r.queue_full = (q_count >= cap);
      r.queue_empty = (q_count == 0);
      r.last = (k == step_words.size() - 1);
      expected_words = {expected_words, r};
    end
  endtask

  // register write, mirrored into the behavioral copy
  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_KIND: r_kind = val[1:0];
      CFG_CAP: r_cap = val;
      CFG_UNIT: r_units = val[2:0];
      default: ;
    endcase
  endtask

  // wait for every expected word, then let a select walk die out
  task automatic drain();
    req.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // send one word; it is accepted at the edge where ready is seen high
  task automatic send_word(input req_word_t w);
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= w;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_queue(w);
  endtask

  function automatic req_word_t mk(input int rt, input int k,
                                   input int s1v, input int s1t, input int s1p,
                                   input int s2v, input int s2t, input int s2p,
                                   input int dv, input int dt, input int odt,
                                   input int sa);
    req_word_t w;
    w.req_type = 3'(rt); w.entry_kind = 2'(k);
    w.src1_valid = 1'(s1v); w.src1_tag = tag_t'(s1t); w.src1_pending = 1'(s1p);
    w.src2_valid = 1'(s2v); w.src2_tag = tag_t'(s2t); w.src2_pending = 1'(s2p);
    w.dest_valid = 1'(dv); w.dest_tag = tag_t'(dt); w.old_dest_tag = tag_t'(odt);
    w.stores_ahead = 4'(sa);
    return w;
  endfunction

  // random word: mostly enqueue, select and tick over a small tag pool
  function automatic req_word_t rand_word(input logic [1:0] qk);
    req_word_t   w;
    logic [63:0] bits;
    int          p;
    bits = {$urandom, $urandom};
    w = bits[$bits(req_word_t)-1:0];
    p = $urandom_range(99);
    w.req_type = (p < 32) ? REQ_ENQ : (p < 50) ? REQ_WAKE : (p < 72) ? REQ_SEL :
                 (p < 90) ? REQ_TICK : (p < 97) ? REQ_SDONE : 3'($urandom_range(5, 7));
    if ($urandom_range(3) != 0) w.entry_kind = qk;
    if ($urandom_range(3) != 0) begin
      w.src1_tag = tag_t'($urandom_range(7));
      w.src2_tag = tag_t'($urandom_range(7));
      w.dest_tag = tag_t'($urandom_range(7));
    end
    if ($urandom_range(1) != 0) w.stores_ahead = 4'($urandom_range(2));
    return w;
  endfunction

  // receiver: random stalls, compare every word taken
  always @(posedge clk) begin
    res_word_t exp_w;
    if (rst) res.ready <= 1'b0;
    else begin
      if (res.valid && res.ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, res.data);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (res.data !== exp_w) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_w, res.data);
            errors++;
          end
        end
      end
      res.ready <= !(rcv_idle > 0 && $urandom_range(99) < rcv_idle);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("Verification failed");
      $finish;
    end
  end

  // directed rows; a row with check set carries its own expected word
  typedef struct {
    req_word_t w;
    logic      check;
    res_word_t r;
  } row_t;
  row_t rows [$];

  initial begin
    row_t      rw;
    res_word_t st;
    req_word_t w;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_KIND;
    cfg_data = '0;
    req.valid = 1'b0;
    req.data = '0;
    errors = 0;
    cycles = 0;
    snd_idle = 0;
    rcv_idle = 0;
    q_count = 0;
    r_kind = 2'd0; r_cap = 5'd16; r_units = 3'd4;
    for (int i = 0; i < MAX_UNITS; i++) begin
      u_busy[i] = 1'b0; u_left[i] = 0; u_kind[i] = '0;
      u_dv[i] = 1'b0; u_dt[i] = '0; u_odt[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: tick, select and an unknown request type on an empty queue give a bare status
    st = status_word(1'b0);
    st.queue_empty = 1'b1;
    st.last = 1'b1;
    rw.check = 1'b1; rw.r = st;
    rw.w = mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_SEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(7, 3, 1, 127, 1, 1, 127, 1, 1, 127, 127, 15); rows = {rows, rw};
    rw.check = 1'b0;
    // extremes, wakeup chain, both sources, load and store kinds
    rw.w = mk(REQ_ENQ, 0, 1, 127, 1, 1, 0, 1, 1, 5, 127, 15); rows = {rows, rw};
    rw.w = mk(REQ_ENQ, 0, 1, 5, 1, 0, 9, 1, 1, 127, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_ENQ, 2, 0, 0, 0, 0, 0, 0, 1, 3, 4, 1); rows = {rows, rw};
    rw.w = mk(REQ_SEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_WAKE, 0, 0, 0, 0, 0, 0, 0, 0, 127, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_WAKE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_SEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_SDONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_SDONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_ENQ, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_ENQ, 3, 0, 0, 0, 0, 0, 0, 1, 9, 8, 0); rows = {rows, rw};
    rw.w = mk(5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};
    rw.w = mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0); rows = {rows, rw};

    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].check) begin
        expected_words.pop_back();
        expected_words = {expected_words, rows[i].r};
      end
    end
    drain();

    // capacity zero: every enqueue dropped
    write_reg(CFG_CAP, 5'd0);
    send_word(mk(REQ_ENQ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // random phases over register settings, extremes included
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(CFG_KIND, 5'(ph % 4));
      write_reg(CFG_CAP, (ph == 3) ? 5'd31 : (ph == 5) ? 5'd1 : 5'($urandom_range(1, 17)));
      write_reg(CFG_UNIT, (ph == 2) ? 5'd7 : (ph == 6) ? 5'd0 : 5'($urandom_range(1, 4)));
      if (ph < 4) begin snd_idle = 36; rcv_idle = 47; end
      else if (ph < 8) begin snd_idle = 47; rcv_idle = 36; end
      else begin snd_idle = 0; rcv_idle = 0; end
      for (int n = 0; n < 30; n++) begin
        w = rand_word(r_kind);
        send_word(w);
        // sender holds off until the queue of expected words empties
        if (n == 15) begin
          req.valid <= 1'b0;
          @(posedge clk);
          while (expected_words.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
